@@ hdl/pts_pkg.sv @@
// Shared types and constants for the periodic task scheduler.
package pts_pkg;

   localparam int TIME_W = 64;
   localparam int KIND_W = 4;
   localparam int STATUS_W = 3;

   localparam int DEF_MAX_TASKS = 64;
   localparam int DEF_MAX_GROUPS = 32;
   localparam int DEF_LEVEL_BITS = 16;

   // Item kinds.
   typedef enum logic [KIND_W-1:0] {
      K_ADVANCE    = 4'd0,
      K_ADD_GROUP  = 4'd1,
      K_ADD_TASK   = 4'd2,
      K_CHANGE_IVL = 4'd3,
      K_TASK_ON    = 4'd4,
      K_TASK_OFF   = 4'd5,
      K_GROUP_ON   = 4'd6,
      K_GROUP_OFF  = 4'd7,
      K_REWIND     = 4'd8
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_NO_TASK  = 3'd2,
      ST_NO_GROUP = 3'd3,
      ST_ZERO_IVL = 3'd4
   } status_type;

   // Operations broadcast to the task cells.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SET_DUE,
      OP_SET_IVL,
      OP_SET_ON,
      OP_REWIND
   } op_type;

   // Command word seen by every cell in the same cycle.
   typedef struct packed {
      op_type op;
      logic   on_val;   // new enable for OP_SET_ON
      logic   upd_due;  // OP_SET_IVL also loads the due time
      logic   fetch;    // chain carries the addressed task instead of the best one
   } cell_cmd_type;

endpackage

@@ hdl/pts_cell.sv @@
// One task entry of the scheduler chain with its ranking stage.
module pts_cell import pts_pkg::*; #(
   parameter int CELL_IDX   = 0,
   parameter int TIW        = 6,
   parameter int TCW        = 7,
   parameter int GIW        = 5,
   parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
   input  logic                         clock,
   input  cell_cmd_type                 cmd,
   input  logic [TIW-1:0]               target,
   input  logic [TCW-1:0]               count,
   input  logic [TIME_W-1:0]            wr_due,
   input  logic [TIME_W-1:0]            wr_ivl,
   input  logic [GIW-1:0]               wr_group,
   input  logic signed [LEVEL_BITS-1:0] wr_glevel,
   input  logic signed [LEVEL_BITS-1:0] wr_tlevel,
   input  logic                         in_valid,
   input  logic [TIME_W-1:0]            in_due,
   input  logic [TIME_W-1:0]            in_origin,
   input  logic [TIME_W-1:0]            in_ivl,
   input  logic [GIW-1:0]               in_group,
   input  logic signed [LEVEL_BITS-1:0] in_glevel,
   input  logic                         in_on,
   input  logic signed [LEVEL_BITS-1:0] in_tlevel,
   input  logic [TIW-1:0]               in_idx,
   output logic                         out_valid,
   output logic [TIME_W-1:0]            out_due,
   output logic [TIME_W-1:0]            out_origin,
   output logic [TIME_W-1:0]            out_ivl,
   output logic [GIW-1:0]               out_group,
   output logic signed [LEVEL_BITS-1:0] out_glevel,
   output logic                         out_on,
   output logic signed [LEVEL_BITS-1:0] out_tlevel,
   output logic [TIW-1:0]               out_idx
);

   localparam logic [TIW-1:0] MY_IDX = TIW'(CELL_IDX);

   logic [TIME_W-1:0]            due_ff, origin_ff, ivl_ff;
   logic [GIW-1:0]               group_ff;
   logic signed [LEVEL_BITS-1:0] glevel_ff, tlevel_ff;
   logic                         on_ff;

   logic                         valid_ff;
   logic [TIME_W-1:0]            odue_ff, oorigin_ff, oivl_ff;
   logic [GIW-1:0]               ogroup_ff;
   logic signed [LEVEL_BITS-1:0] oglevel_ff, otlevel_ff;
   logic                         oon_ff;
   logic [TIW-1:0]               oidx_ff;

   logic live, hit, ahead, take_own;

   assign live = (TCW'(CELL_IDX) < count);
   assign hit  = (target == MY_IDX);

   // Entry storage, written by the broadcast command.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ADD: begin
            if (hit) begin
               due_ff    <= wr_due;
               origin_ff <= wr_due;
               ivl_ff    <= wr_ivl;
               group_ff  <= wr_group;
               glevel_ff <= wr_glevel;
               tlevel_ff <= wr_tlevel;
               on_ff     <= 1'b1;
            end
         end
         OP_SET_DUE: begin
            if (hit) due_ff <= wr_due;
         end
         OP_SET_IVL: begin
            if (hit) begin
               ivl_ff <= wr_ivl;
               if (cmd.upd_due) due_ff <= wr_due;
            end
         end
         OP_SET_ON: begin
            if (hit) on_ff <= cmd.on_val;
         end
         OP_REWIND: begin
            if (live) due_ff <= origin_ff;
         end
         default: ;
      endcase
   end

   // This entry strictly outranks the incoming candidate; ties go to the lower slot.
   always_comb begin
      if (due_ff != in_due)             ahead = (due_ff < in_due);
      else if (glevel_ff != in_glevel)  ahead = (glevel_ff > in_glevel);
      else if (group_ff != in_group)    ahead = (group_ff < in_group);
      else                              ahead = (tlevel_ff > in_tlevel);
   end

   assign take_own = live && (cmd.fetch ? hit : (!in_valid || ahead));

   // Candidate stage handed to the next cell.
   always_ff @(posedge clock) begin
      if (take_own) begin
         valid_ff   <= 1'b1;
         odue_ff    <= due_ff;
         oorigin_ff <= origin_ff;
         oivl_ff    <= ivl_ff;
         ogroup_ff  <= group_ff;
         oglevel_ff <= glevel_ff;
         oon_ff     <= on_ff;
         otlevel_ff <= tlevel_ff;
         oidx_ff    <= MY_IDX;
      end else begin
         valid_ff   <= in_valid;
         odue_ff    <= in_due;
         oorigin_ff <= in_origin;
         oivl_ff    <= in_ivl;
         ogroup_ff  <= in_group;
         oglevel_ff <= in_glevel;
         oon_ff     <= in_on;
         otlevel_ff <= in_tlevel;
         oidx_ff    <= in_idx;
      end
   end

   assign out_valid  = valid_ff;
   assign out_due    = odue_ff;
   assign out_origin = oorigin_ff;
   assign out_ivl    = oivl_ff;
   assign out_group  = ogroup_ff;
   assign out_glevel = oglevel_ff;
   assign out_on     = oon_ff;
   assign out_tlevel = otlevel_ff;
   assign out_idx    = oidx_ff;

endmodule

@@ hdl/pts_divider.sv @@
// Bit-serial restoring divider that returns the remainder.
module pts_divider import pts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [TIME_W-1:0] rem
);

   localparam int CW = $clog2(TIME_W + 1);

   logic [TIME_W-1:0] rem_ff, num_ff, den_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff, done_ff;
   logic [TIME_W:0]   trial;
   logic [TIME_W-1:0] rem_in;

   // One quotient bit per cycle.
   always_comb begin
      trial = {rem_ff, num_ff[TIME_W-1]};
      if (trial >= {1'b0, den_ff}) rem_in = TIME_W'(trial - {1'b0, den_ff});
      else                         rem_in = trial[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            num_ff  <= dividend;
            den_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[TIME_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(TIME_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ hdl/periodic_task_scheduler.sv @@
// Top level of the periodic task scheduler: control sequencer, group table and task chain.
//
// Commands arrive as words on the req_ channel (kind in req_tuser, operands in
// req_tdata); each produces exactly one result word on the rsp_ channel.
// Tasks live in a chain of MAX_TASKS cells. Choosing the head task is a ranking
// pass that moves a candidate down the chain one cell per cycle. Every command
// ends with such a pass to report the head. An advance first runs an extra
// ranking pass to pop the head task; a change of interval first runs a fetch
// pass and, when the due time is past the origin, a run of the divider.
// One command is in work at a time; req_tready is high only between commands.
// The result is held in an output register, so a new command is taken while
// the previous result still waits; a stalled receiver only holds back the
// loading of the next result. Reset empties the task and group tables
// (counts go to zero) and drops any pending result; no clearing pass is needed.
module periodic_task_scheduler import pts_pkg::*; #(
   parameter int MAX_TASKS  = DEF_MAX_TASKS,
   parameter int MAX_GROUPS = DEF_MAX_GROUPS,
   parameter int LEVEL_BITS = DEF_LEVEL_BITS,
   localparam int TIW = $clog2(MAX_TASKS),
   localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
   localparam int IN_BITS = TIW + GIW + LEVEL_BITS + 2 * TIME_W,
   localparam int IN_W = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS = STATUS_W + TIW + GIW + 2 + 3 * TIME_W + LEVEL_BITS,
   localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // task_slot, group_slot, level, start_time, interval (lowest first)
   input  logic [IN_W-1:0]   req_tdata,
   // kind
   input  logic [KIND_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status, slot_out, group_out, popped, ran, run_time, head_time, head_level
   output logic [OUT_W-1:0]  rsp_tdata
);

   localparam int TCW = $clog2(MAX_TASKS + 1);
   localparam int GCW = $clog2(MAX_GROUPS + 1);
   localparam int SCAN_LEN = MAX_TASKS + 1;
   localparam int SW = $clog2(SCAN_LEN + 1);
   localparam int O_GS = TIW;
   localparam int O_LV = O_GS + GIW;
   localparam int O_ST = O_LV + LEVEL_BITS;
   localparam int O_IV = O_ST + TIME_W;
   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_POP_SCAN, S_FETCH, S_DIV, S_HEAD, S_DONE
   } state_type;

   state_type state_ff;

   // Latched command word.
   logic [KIND_W-1:0]            kind_ff;
   logic [TIW-1:0]               tslot_ff;
   logic [GIW-1:0]               gslot_ff;
   logic signed [LEVEL_BITS-1:0] level_ff;
   logic [TIME_W-1:0]            start_ff, ivl_ff;

   logic [TCW-1:0] tcount_ff;
   logic [GCW-1:0] gcount_ff;
   logic [SW-1:0]  scan_ff;

   logic signed [LEVEL_BITS-1:0] group_level_ff [MAX_GROUPS];
   logic [MAX_GROUPS-1:0]        group_on_ff;

   // Broadcast to the cells.
   cell_cmd_type                 cmd_ff;
   logic [TIW-1:0]               target_ff;
   logic [TIME_W-1:0]            wr_due_ff, wr_ivl_ff;
   logic [GIW-1:0]               wr_group_ff;
   logic signed [LEVEL_BITS-1:0] wr_glevel_ff, wr_tlevel_ff;

   // Result fields under construction and registered result.
   status_type                   status_ff;
   logic [TIW-1:0]               slot_ff;
   logic [GIW-1:0]               gout_ff;
   logic                         popped_ff, ran_ff;
   logic [TIME_W-1:0]            rtime_ff;
   logic [OUT_BITS-1:0]          rsp_data_ff;
   logic                         rsp_valid_ff;

   logic [TIME_W-1:0] origin_ff, rel_ff;
   logic              div_start_ff, div_done;
   logic [TIME_W-1:0] div_rem;

   // Candidate chain; entry zero feeds an empty candidate into the first cell.
   logic                         ch_valid  [MAX_TASKS+1];
   logic [TIME_W-1:0]            ch_due    [MAX_TASKS+1];
   logic [TIME_W-1:0]            ch_origin [MAX_TASKS+1];
   logic [TIME_W-1:0]            ch_ivl    [MAX_TASKS+1];
   logic [GIW-1:0]               ch_group  [MAX_TASKS+1];
   logic signed [LEVEL_BITS-1:0] ch_glevel [MAX_TASKS+1];
   logic                         ch_on     [MAX_TASKS+1];
   logic signed [LEVEL_BITS-1:0] ch_tlevel [MAX_TASKS+1];
   logic [TIW-1:0]               ch_idx    [MAX_TASKS+1];

   assign ch_valid[0]  = 1'b0;
   assign ch_due[0]    = '0;
   assign ch_origin[0] = '0;
   assign ch_ivl[0]    = '0;
   assign ch_group[0]  = '0;
   assign ch_glevel[0] = '0;
   assign ch_on[0]     = 1'b0;
   assign ch_tlevel[0] = '0;
   assign ch_idx[0]    = '0;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      pts_cell #(
         .CELL_IDX(i), .TIW(TIW), .TCW(TCW), .GIW(GIW), .LEVEL_BITS(LEVEL_BITS)
      ) u_cell (
         .clock(clock), .cmd(cmd_ff), .target(target_ff), .count(tcount_ff),
         .wr_due(wr_due_ff), .wr_ivl(wr_ivl_ff), .wr_group(wr_group_ff),
         .wr_glevel(wr_glevel_ff), .wr_tlevel(wr_tlevel_ff),
         .in_valid(ch_valid[i]), .in_due(ch_due[i]), .in_origin(ch_origin[i]),
         .in_ivl(ch_ivl[i]), .in_group(ch_group[i]), .in_glevel(ch_glevel[i]),
         .in_on(ch_on[i]), .in_tlevel(ch_tlevel[i]), .in_idx(ch_idx[i]),
         .out_valid(ch_valid[i+1]), .out_due(ch_due[i+1]),
         .out_origin(ch_origin[i+1]), .out_ivl(ch_ivl[i+1]),
         .out_group(ch_group[i+1]), .out_glevel(ch_glevel[i+1]),
         .out_on(ch_on[i+1]), .out_tlevel(ch_tlevel[i+1]), .out_idx(ch_idx[i+1])
      );
   end

   pts_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(rel_ff), .divisor(ivl_ff), .done(div_done), .rem(div_rem)
   );

   // Chain end after a full pass.
   logic                         head_valid;
   logic [TIME_W-1:0]            head_due, head_ivl, head_origin;
   logic [GIW-1:0]               head_group;
   logic [TIME_W:0]              pop_sum;
   logic [TIME_W-1:0]            base, reproj;
   logic [TIME_W:0]              reproj_sum;
   logic                         scan_end;

   assign head_valid  = ch_valid[MAX_TASKS];
   assign head_due    = ch_due[MAX_TASKS];
   assign head_ivl    = ch_ivl[MAX_TASKS];
   assign head_origin = ch_origin[MAX_TASKS];
   assign head_group  = ch_group[MAX_TASKS];
   assign scan_end    = (scan_ff == SW'(SCAN_LEN));

   // Saturating reschedule of the popped task.
   assign pop_sum = {1'b0, head_due} + {1'b0, head_ivl};

   // Re-projection: floor(rel / new) * new equals rel minus the remainder.
   assign base       = rel_ff - div_rem + origin_ff;
   assign reproj_sum = {1'b0, base} + {1'b0, ivl_ff};
   assign reproj     = reproj_sum[TIME_W] ? '1 : reproj_sum[TIME_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_data_ff);

   // Command sequencer with group table and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tcount_ff    <= '0;
         gcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         scan_ff      <= '0;
         cmd_ff       <= '{op: OP_NONE, on_val: 1'b0, upd_due: 1'b0, fetch: 1'b0};
      end else begin
         cmd_ff.op    <= OP_NONE;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff   <= req_tuser;
                  tslot_ff  <= req_tdata[TIW-1:0];
                  gslot_ff  <= req_tdata[O_LV-1:O_GS];
                  level_ff  <= req_tdata[O_ST-1:O_LV];
                  start_ff  <= req_tdata[O_IV-1:O_ST];
                  ivl_ff    <= req_tdata[O_IV+TIME_W-1:O_IV];
                  status_ff <= ST_OK;
                  slot_ff   <= '0;
                  gout_ff   <= '0;
                  popped_ff <= 1'b0;
                  ran_ff    <= 1'b0;
                  rtime_ff  <= '0;
                  state_ff  <= S_EXEC;
               end
            end

            S_EXEC: begin
               scan_ff      <= '0;
               cmd_ff.fetch <= 1'b0;
               state_ff     <= S_HEAD;
               priority case (kind_type'(kind_ff))
                  K_ADVANCE: begin
                     if (tcount_ff != '0) state_ff <= S_POP_SCAN;
                  end
                  K_ADD_GROUP: begin
                     if (gcount_ff == GCW'(MAX_GROUPS)) begin
                        status_ff <= ST_FULL;
                     end else begin
                        group_level_ff[GIW'(gcount_ff)] <= level_ff;
                        group_on_ff[GIW'(gcount_ff)]    <= 1'b1;
                        gout_ff   <= GIW'(gcount_ff);
                        gcount_ff <= gcount_ff + GCW'(1);
                     end
                  end
                  K_ADD_TASK: begin
                     if (tcount_ff == TCW'(MAX_TASKS)) begin
                        status_ff <= ST_FULL;
                     end else if (GCW'(gslot_ff) >= gcount_ff) begin
                        status_ff <= ST_NO_GROUP;
                     end else begin
                        cmd_ff.op    <= OP_ADD;
                        target_ff    <= TIW'(tcount_ff);
                        wr_due_ff    <= start_ff;
                        wr_ivl_ff    <= ivl_ff;
                        wr_group_ff  <= gslot_ff;
                        wr_glevel_ff <= group_level_ff[gslot_ff];
                        wr_tlevel_ff <= level_ff;
                        slot_ff      <= TIW'(tcount_ff);
                        tcount_ff    <= tcount_ff + TCW'(1);
                     end
                  end
                  K_CHANGE_IVL: begin
                     if (TCW'(tslot_ff) >= tcount_ff) begin
                        status_ff <= ST_NO_TASK;
                     end else if (ivl_ff == '0) begin
                        status_ff <= ST_ZERO_IVL;
                     end else begin
                        cmd_ff.fetch <= 1'b1;
                        target_ff    <= tslot_ff;
                        state_ff     <= S_FETCH;
                     end
                  end
                  K_TASK_ON, K_TASK_OFF: begin
                     if (TCW'(tslot_ff) >= tcount_ff) begin
                        status_ff <= ST_NO_TASK;
                     end else begin
                        cmd_ff.op     <= OP_SET_ON;
                        cmd_ff.on_val <= (kind_type'(kind_ff) == K_TASK_ON);
                        target_ff     <= tslot_ff;
                     end
                  end
                  K_GROUP_ON, K_GROUP_OFF: begin
                     if (GCW'(gslot_ff) >= gcount_ff) begin
                        status_ff <= ST_NO_GROUP;
                     end else begin
                        group_on_ff[gslot_ff] <= (kind_type'(kind_ff) == K_GROUP_ON);
                     end
                  end
                  K_REWIND: begin
                     cmd_ff.op <= OP_REWIND;
                  end
                  default: ;
               endcase
            end

            // Ranking pass, then reschedule the winner.
            S_POP_SCAN: begin
               scan_ff <= scan_ff + SW'(1);
               if (scan_end) begin
                  popped_ff   <= 1'b1;
                  slot_ff     <= ch_idx[MAX_TASKS];
                  rtime_ff    <= head_due;
                  ran_ff      <= ch_on[MAX_TASKS] && group_on_ff[head_group];
                  cmd_ff.op   <= OP_SET_DUE;
                  target_ff   <= ch_idx[MAX_TASKS];
                  wr_due_ff   <= pop_sum[TIME_W] ? '1 : pop_sum[TIME_W-1:0];
                  scan_ff     <= '0;
                  state_ff    <= S_HEAD;
               end
            end

            // Fetch pass brings the addressed task to the chain end.
            S_FETCH: begin
               scan_ff <= scan_ff + SW'(1);
               if (scan_end) begin
                  scan_ff      <= '0;
                  cmd_ff.fetch <= 1'b0;
                  origin_ff    <= head_origin;
                  rel_ff       <= head_due - head_ivl - head_origin;
                  if (head_due > head_origin) begin
                     div_start_ff <= 1'b1;
                     state_ff     <= S_DIV;
                  end else begin
                     cmd_ff.op      <= OP_SET_IVL;
                     cmd_ff.upd_due <= 1'b0;
                     wr_ivl_ff      <= ivl_ff;
                     state_ff       <= S_HEAD;
                  end
               end
            end

            S_DIV: begin
               if (div_done) begin
                  cmd_ff.op      <= OP_SET_IVL;
                  cmd_ff.upd_due <= 1'b1;
                  wr_ivl_ff      <= ivl_ff;
                  wr_due_ff      <= reproj;
                  scan_ff        <= '0;
                  state_ff       <= S_HEAD;
               end
            end

            // Final ranking pass for the head report.
            S_HEAD: begin
               scan_ff <= scan_ff + SW'(1);
               if (scan_end) state_ff <= S_DONE;
            end

            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {
                     head_valid ? ch_glevel[MAX_TASKS] : LEVEL_MIN,
                     head_valid ? head_due : {TIME_W{1'b1}},
                     rtime_ff, ran_ff, popped_ff, gout_ff, slot_ff, status_ff
                  };
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Table counts never pass their capacity.
   assert property (@(posedge clock) disable iff (reset) tcount_ff <= TCW'(MAX_TASKS))
      else $error("task count beyond capacity");
   assert property (@(posedge clock) disable iff (reset) gcount_ff <= GCW'(MAX_GROUPS))
      else $error("group count beyond capacity");
   // A popped task always comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[STATUS_W+TIW+GIW] |-> rsp_data_ff[STATUS_W-1:0] == ST_OK)
      else $error("popped result with error status");
   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");
   // A head pass with tasks present ends with a valid candidate.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HEAD && scan_end && tcount_ff != '0 |-> head_valid)
      else $error("head pass found no task");

endmodule

@@ bench/pts_checker.sv @@
// Checker for the periodic task scheduler: it predicts each result word and compares it.
module pts_checker import pts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [159:0] req_tdata,
   input  logic [3:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [223:0] rsp_tdata,
   output int           fail_count,
   output int           pending,
   output int           ran_count,
   output int           word_count
);

   localparam int NT = 64;
   localparam int NG = 32;
   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      logic [2:0]   status;
      logic [5:0]   slot;
      logic [4:0]   grp;
      logic         popped;
      logic         ran;
      logic [63:0]  run_time;
      logic [63:0]  head_time;
      logic [15:0]  head_level;
   } sched_result_t;

   // Shadow copy of the task and group tables.
   logic [63:0]        due_q [NT];
   logic [63:0]        org_q [NT];
   logic [63:0]        ivl_q [NT];
   logic [4:0]         own_q [NT];
   logic signed [15:0] tlvl_q [NT];
   logic               ton_q [NT];
   int                 ntasks;
   logic signed [15:0] glvl_q [NG];
   logic               gon_q [NG];
   int                 ngroups;

   sched_result_t expected_results [$];

   // True when task a ranks ahead of task b.
   function automatic bit ranks_ahead(int a, int b);
      if (due_q[a] != due_q[b]) return due_q[a] < due_q[b];
      if (glvl_q[own_q[a]] != glvl_q[own_q[b]])
         return glvl_q[own_q[a]] > glvl_q[own_q[b]];
      if (own_q[a] != own_q[b]) return own_q[a] < own_q[b];
      if (tlvl_q[a] != tlvl_q[b]) return tlvl_q[a] > tlvl_q[b];
      return a < b;
   endfunction

   function automatic int head_task();
      int best;
      best = 0;
      for (int i = 1; i < ntasks; i++)
         if (ranks_ahead(i, best)) best = i;
      return best;
   endfunction

   // Apply one command word to the shadow tables and return its result.
   function automatic sched_result_t schedule_step(logic [3:0] kind, logic [159:0] d);
      sched_result_t r;
      logic [5:0]         ts;
      logic [4:0]         gs;
      logic signed [15:0] lvl;
      logic [63:0]        st, iv, nxt, rel;
      int                 t;
      ts  = d[5:0];
      gs  = d[10:6];
      lvl = d[26:11];
      st  = d[90:27];
      iv  = d[154:91];
      r = '0;
      r.head_time  = ALL_ONES;
      r.head_level = 16'h8000;
      case (kind)
         K_ADVANCE: begin
            if (ntasks > 0) begin
               t = head_task();
               nxt = due_q[t] + ivl_q[t];
               if (nxt < ivl_q[t]) nxt = ALL_ONES;
               r.run_time = due_q[t];
               due_q[t] = nxt;
               r.popped = 1'b1;
               r.slot = 6'(t);
               r.ran = ton_q[t] && gon_q[own_q[t]];
            end
         end
         K_ADD_GROUP: begin
            if (ngroups >= NG) r.status = ST_FULL;
            else begin
               glvl_q[ngroups] = lvl;
               gon_q[ngroups] = 1'b1;
               r.grp = 5'(ngroups);
               ngroups++;
            end
         end
         K_ADD_TASK: begin
            if (ntasks >= NT) r.status = ST_FULL;
            else if (gs >= ngroups) r.status = ST_NO_GROUP;
            else begin
               due_q[ntasks] = st;
               org_q[ntasks] = st;
               ivl_q[ntasks] = iv;
               own_q[ntasks] = gs;
               tlvl_q[ntasks] = lvl;
               ton_q[ntasks] = 1'b1;
               r.slot = 6'(ntasks);
               ntasks++;
            end
         end
         K_CHANGE_IVL: begin
            if (ts >= ntasks) r.status = ST_NO_TASK;
            else if (iv == 0) r.status = ST_ZERO_IVL;
            else begin
               // Re-project the schedule onto the new interval.
               if (due_q[ts] > org_q[ts]) begin
                  rel = due_q[ts] - ivl_q[ts] - org_q[ts];
                  nxt = (rel / iv) * iv + org_q[ts] + iv;
                  if (nxt < iv) nxt = ALL_ONES;
                  due_q[ts] = nxt;
               end
               ivl_q[ts] = iv;
            end
         end
         K_TASK_ON, K_TASK_OFF: begin
            if (ts >= ntasks) r.status = ST_NO_TASK;
            else ton_q[ts] = (kind == K_TASK_ON);
         end
         K_GROUP_ON, K_GROUP_OFF: begin
            if (gs >= ngroups) r.status = ST_NO_GROUP;
            else gon_q[gs] = (kind == K_GROUP_ON);
         end
         K_REWIND: begin
            for (int i = 0; i < ntasks; i++) due_q[i] = org_q[i];
         end
         default: ;
      endcase
      if (ntasks > 0) begin
         t = head_task();
         r.head_time = due_q[t];
         r.head_level = glvl_q[own_q[t]];
      end
      return r;
   endfunction

   // Watch both channels; a command word queues a prediction, a result word is checked.
   always @(posedge clock) begin
      sched_result_t exp_r, act;
      if (reset) begin
         ntasks = 0;
         ngroups = 0;
         expected_results.delete();
         fail_count <= 0;
         ran_count <= 0;
         word_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act.status     = rsp_tdata[2:0];
            act.slot       = rsp_tdata[8:3];
            act.grp        = rsp_tdata[13:9];
            act.popped     = rsp_tdata[14];
            act.ran        = rsp_tdata[15];
            act.run_time   = rsp_tdata[79:16];
            act.head_time  = rsp_tdata[143:80];
            act.head_level = rsp_tdata[159:144];
            word_count <= word_count + 1;
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", act);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (act.ran) ran_count <= ran_count + 1;
               if (act !== exp_r) begin
                  if (fail_count < 10)
                     $display("mismatch: expected st=%0d slot=%0d grp=%0d pop=%0d ran=%0d run=%h head=%h lvl=%h, actual st=%0d slot=%0d grp=%0d pop=%0d ran=%0d run=%h head=%h lvl=%h",
                        exp_r.status, exp_r.slot, exp_r.grp, exp_r.popped, exp_r.ran,
                        exp_r.run_time, exp_r.head_time, exp_r.head_level,
                        act.status, act.slot, act.grp, act.popped, act.ran,
                        act.run_time, act.head_time, act.head_level);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(schedule_step(req_tuser, req_tdata));
      end
      pending <= expected_results.size();
   end

endmodule

@@ bench/tb_top.sv @@
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
module tb_top;
   import pts_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;   // task_slot, group_slot, level, start_time, interval
   logic [3:0]   req_tuser = '0;   // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;        // status, slot_out, group_out, popped, ran, run_time,
                                   // head_time, head_level
   int  fail_count, pending, ran_count, word_count;
   bit  quiet = 0;
   bit  hold_req = 0;
   int  sent = 0;

   always #6 clock = ~clock;

   periodic_task_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   pts_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending),
      .ran_count(ran_count), .word_count(word_count)
   );

   // Offer one command word and wait until it is taken.
   task automatic send_cmd(logic [3:0] kind, logic [5:0] ts, logic [4:0] gs,
                           logic [15:0] lvl, logic [63:0] st, logic [63:0] iv);
      while (!quiet && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'b0, iv, st, lvl, gs, ts};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Times and intervals: small ones to keep the schedule moving, plus the extremes.
   function automatic logic [63:0] rand_time();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return {$urandom, $urandom};
         2: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 50);
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   // Receiver: random stalls, one long hold-off while the sender keeps offering.
   initial begin
      bit held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            held = 1;
         end else begin
            rsp_tready <= quiet || $urandom_range(0, 99) >= 29;
         end
      end
   end

   initial begin
      #48_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int r, wait_cycles;
      logic [3:0] k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, level extremes, errors and saturation.
      send_cmd(K_ADVANCE, 0, 0, 0, 0, 0);
      send_cmd(K_ADD_TASK, 0, 0, 0, 5, 5);
      send_cmd(K_TASK_ON, 0, 0, 0, 0, 0);
      send_cmd(K_ADD_GROUP, 0, 0, 16'h7FFF, 0, 0);
      send_cmd(K_ADD_GROUP, 0, 0, 16'h8000, 0, 0);
      send_cmd(K_ADD_GROUP, 0, 0, 16'h0000, 0, 0);
      send_cmd(K_ADD_TASK, 0, 5'd31, 0, 0, 1);
      send_cmd(K_ADD_TASK, 0, 0, 16'h8000, 0, 0);
      send_cmd(K_ADD_TASK, 0, 1, 16'h7FFF, 100, 10);
      send_cmd(K_ADD_TASK, 0, 2, 0, 64'hFFFF_FFFF_FFFF_FFFA, '1);
      send_cmd(K_CHANGE_IVL, 6'd63, 0, 0, 0, 3);
      send_cmd(K_CHANGE_IVL, 1, 0, 0, 0, 0);
      send_cmd(K_ADVANCE, 0, 0, 0, 0, 0);
      send_cmd(K_ADVANCE, 0, 0, 0, 0, 0);
      send_cmd(K_CHANGE_IVL, 1, 0, 0, 0, 7);
      send_cmd(K_TASK_OFF, 1, 0, 0, 0, 0);
      send_cmd(K_GROUP_OFF, 0, 0, 0, 0, 0);
      send_cmd(K_GROUP_ON, 0, 5'd9, 0, 0, 0);
      send_cmd(K_ADVANCE, 0, 0, 0, 0, 0);
      send_cmd(K_REWIND, 0, 0, 0, 0, 0);
      send_cmd(4'd9, '1, '1, '1, '1, '1);
      send_cmd(4'd15, 0, 0, 0, 0, 0);
      send_cmd(K_TASK_ON, 1, 0, 0, 0, 0);
      send_cmd(K_GROUP_ON, 0, 0, 0, 0, 0);
      send_cmd(K_ADVANCE, 0, 0, 0, 0, 0);

      // Random part, weighted toward advances over a growing table.
      for (int n = 0; n < 1550; n++) begin
         quiet = (n >= 200 && n < 400);
         if (n == 700) hold_req = 1;
         r = $urandom_range(0, 99);
         if (r < 35)      k = K_ADVANCE;
         else if (r < 50) k = K_ADD_TASK;
         else if (r < 56) k = K_ADD_GROUP;
         else if (r < 66) k = K_CHANGE_IVL;
         else if (r < 74) k = $urandom_range(0, 1) ? K_TASK_ON : K_TASK_OFF;
         else if (r < 82) k = $urandom_range(0, 1) ? K_GROUP_ON : K_GROUP_OFF;
         else if (r < 86) k = K_REWIND;
         else if (r < 89) k = $urandom_range(9, 15);
         else             k = K_ADVANCE;
         send_cmd(k,
                  $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 15),
                  $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 7),
                  $urandom, rand_time(), rand_time());
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every predicted word, then a little longer.
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while ((pending != 0 || wait_cycles < 2) && wait_cycles < 20000);
      repeat (300) @(posedge clock);

      $display("Sent %0d command words, checked %0d result words; %0d tasks ran.",
               sent, word_count, ran_count);
      $display("Covered table fill, errors, interval changes, rewinds and a long output stall.");
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ periodic_task_scheduler.f @@
hdl/pts_pkg.sv
hdl/pts_cell.sv
hdl/pts_divider.sv
hdl/periodic_task_scheduler.sv
bench/pts_checker.sv
bench/tb_top.sv
